// ===== hdl/mrt_pkg.sv =====
// Package for the missing range tracker: sizes, codes and shared types.
`default_nettype none

package mrt_pkg;

   // Table and offset sizes
   localparam int OFFSET_BITS = 48;
   localparam int MAX_HOLES   = 64;
   localparam int IDX_BITS    = $clog2(MAX_HOLES);
   localparam int CNT_BITS    = $clog2(MAX_HOLES + 1);

   // Widths of the result fields
   localparam int RECV_BITS   = 48;
   localparam int HOLES_BITS  = 7;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_REMOVED = 3'd0,
      STAT_LEFT    = 3'd1,
      STAT_RIGHT   = 3'd2,
      STAT_SPLIT   = 3'd3,
      STAT_EMPTY   = 3'd4,
      STAT_NO_HOLE = 3'd5,
      STAT_OVERRUN = 3'd6,
      STAT_FULL    = 3'd7
   } status_type;

   // Operations of the shared add/compare unit
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // One table entry: the hole [start_ofs, end_ofs)
   typedef struct packed {
      logic [OFFSET_BITS-1:0] start_ofs;
      logic [OFFSET_BITS-1:0] end_ofs;
   } hole_type;

   localparam int HOLE_BITS = $bits(hole_type);

   // Result handed from the sequencer to the output register
   typedef struct packed {
      status_type            status;
      logic [RECV_BITS-1:0]  received;
      logic [HOLES_BITS-1:0] holes;
      logic                  complete;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/mrt_ifs.sv =====
// Request and response channel interfaces of the missing range tracker.
`default_nettype none

interface mrt_req_if;
   logic                            valid;
   logic                            ready;
   logic [mrt_pkg::OFFSET_BITS-1:0] range_start;
   logic [mrt_pkg::OFFSET_BITS-1:0] range_end;

   modport source (output valid, output range_start, output range_end, input ready);
   modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface mrt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     status;
   logic [mrt_pkg::RECV_BITS-1:0]  received_bytes;
   logic [mrt_pkg::HOLES_BITS-1:0] holes_left;
   logic                           complete;

   modport source (output valid, output status, output received_bytes,
                   output holes_left, output complete, input ready);
   modport sink   (input valid, input status, input received_bytes,
                   input holes_left, input complete, output ready);
endinterface

`default_nettype wire

// ===== hdl/mrt_alu.sv =====
// Shared adder/subtractor with less-than and equal flags.
`default_nettype none

module mrt_alu (
   input  mrt_pkg::alu_op_type              op,
   input  logic [mrt_pkg::OFFSET_BITS-1:0]  a,
   input  logic [mrt_pkg::OFFSET_BITS-1:0]  b,
   output logic [mrt_pkg::OFFSET_BITS-1:0]  sum,
   output logic                             lt,
   output logic                             eq
);
   import mrt_pkg::*;

   logic [OFFSET_BITS-1:0] b_eff;
   logic                   carry;

   // Subtract as a plus inverted b plus one
   assign b_eff = (op == ALU_SUB) ? ~b : b;
   assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{OFFSET_BITS{1'b0}}, (op == ALU_SUB)};

   // No carry out of a subtract means a borrow: a < b
   assign lt = (op == ALU_SUB) && !carry;
   assign eq = (sum == '0);

endmodule

`default_nettype wire

// ===== hdl/mrt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module mrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/mrt_seq.sv =====
// Sequencer that searches and edits the hole table through the shared unit.
`default_nettype none

module mrt_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mrt_pkg::OFFSET_BITS-1:0] range_start,
   input  logic [mrt_pkg::OFFSET_BITS-1:0] range_end,
   input  logic                            csr_write_enable,
   input  logic [mrt_pkg::OFFSET_BITS-1:0] csr_write_data,
   output logic                            res_valid,
   input  logic                            res_ready,
   output mrt_pkg::result_type             res
);
   import mrt_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b0000_0000_0001,
      S_CHK_EMPTY = 12'b0000_0000_0010,
      S_SCAN      = 12'b0000_0000_0100,
      S_CHK_END   = 12'b0000_0000_1000,
      S_CHK_START = 12'b0000_0001_0000,
      S_SHIFT_DN  = 12'b0000_0010_0000,
      S_SHIFT_UP  = 12'b0000_0100_0000,
      S_WR_HIGH   = 12'b0000_1000_0000,
      S_WR_LOW    = 12'b0001_0000_0000,
      S_SUB       = 12'b0010_0000_0000,
      S_ADD       = 12'b0100_0000_0000,
      S_RESULT    = 12'b1000_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [OFFSET_BITS-1:0] lo_ff, lo_in;
   logic [OFFSET_BITS-1:0] hi_ff, hi_in;
   logic [OFFSET_BITS-1:0] fstart_ff, fstart_in;
   logic [OFFSET_BITS-1:0] fend_ff, fend_in;
   logic [OFFSET_BITS-1:0] diff_ff, diff_in;
   logic [OFFSET_BITS-1:0] received_ff, received_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [IDX_BITS-1:0]    k_ff, k_in;
   logic [IDX_BITS-1:0]    hi_addr_ff, hi_addr_in;
   logic                   found_ff, found_in;
   logic                   eq_end_ff, eq_end_in;
   logic                   then_low_ff, then_low_in;
   status_type             status_ff, status_in;

   logic [CNT_BITS-1:0]    idx_next;
   logic [CNT_BITS-1:0]    ptr_inc;
   logic [CNT_BITS-1:0]    ptr_dec;
   logic [CNT_BITS-1:0]    ptr_wr_up;
   logic [CNT_BITS-1:0]    k_next;
   logic [CNT_BITS-1:0]    count_last;

   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   hole_type               wr_data;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [HOLE_BITS-1:0]   rd_data;
   hole_type               entry;

   alu_op_type             alu_op;
   logic [OFFSET_BITS-1:0] alu_a;
   logic [OFFSET_BITS-1:0] alu_b;
   logic [OFFSET_BITS-1:0] alu_sum;
   logic                   alu_lt;
   logic                   alu_eq;

   // Hole table
   mrt_ram #(
      .WIDTH (HOLE_BITS),
      .DEPTH (MAX_HOLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared add/compare unit
   mrt_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .sum (alu_sum),
      .lt  (alu_lt),
      .eq  (alu_eq)
   );

   assign entry      = hole_type'(rd_data);
   assign idx_next   = idx_ff + 1'b1;
   assign ptr_inc    = ptr_ff + 1'b1;
   assign ptr_dec    = ptr_ff - 1'b1;
   assign ptr_wr_up  = ptr_ff + 1'b1;
   assign k_next     = {{(CNT_BITS-IDX_BITS){1'b0}}, k_ff} + 1'b1;
   assign count_last = count_ff - 1'b1;

   assign req_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_RESULT);

   // Hand the result over with the state after this transaction
   assign res.status   = status_ff;
   assign res.received = RECV_BITS'(received_ff);
   assign res.holes    = HOLES_BITS'(count_ff);
   assign res.complete = (count_ff == '0);

   // Sequence one transaction
   always_comb begin
      state_in    = state_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      fstart_in   = fstart_ff;
      fend_in     = fend_ff;
      diff_in     = diff_ff;
      received_in = received_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      hi_addr_in  = hi_addr_ff;
      found_in    = found_ff;
      eq_end_in   = eq_end_ff;
      then_low_in = then_low_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_addr     = '0;
      alu_op      = ALU_SUB;
      alu_a       = '0;
      alu_b       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               lo_in    = range_start;
               hi_in    = range_end;
               state_in = S_CHK_EMPTY;
            end
         end
         S_CHK_EMPTY: begin
            // Drop empty ranges, answer no hole for an empty table, else start the scan at entry zero
            alu_a = lo_ff;
            alu_b = hi_ff;
            if (!alu_lt) begin
               status_in = STAT_EMPTY;
               state_in  = S_RESULT;
            end else if (count_ff == '0) begin
               status_in = STAT_NO_HOLE;
               state_in  = S_RESULT;
            end else begin
               rd_addr  = '0;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Keep the last hole that starts at or before the range start
            alu_a = lo_ff;
            alu_b = entry.start_ofs;
            if (!alu_lt) begin
               found_in  = 1'b1;
               k_in      = idx_ff[IDX_BITS-1:0];
               fstart_in = entry.start_ofs;
               fend_in   = entry.end_ofs;
               if (idx_next < count_ff) begin
                  idx_in  = idx_next;
                  rd_addr = idx_next[IDX_BITS-1:0];
               end else begin
                  state_in = S_CHK_END;
               end
            end else if (found_ff) begin
               state_in = S_CHK_END;
            end else begin
               status_in = STAT_NO_HOLE;
               state_in  = S_RESULT;
            end
         end
         S_CHK_END: begin
            // Reject a range running past the hole
            alu_a = fend_ff;
            alu_b = hi_ff;
            if (alu_lt) begin
               status_in = STAT_OVERRUN;
               state_in  = S_RESULT;
            end else begin
               eq_end_in = alu_eq;
               state_in  = S_CHK_START;
            end
         end
         S_CHK_START: begin
            // Pick remove, trim or split, or report a full table
            alu_a = fstart_ff;
            alu_b = lo_ff;
            if (alu_eq && eq_end_ff) begin
               status_in = STAT_REMOVED;
               if (k_next < count_ff) begin
                  rd_addr  = k_next[IDX_BITS-1:0];
                  ptr_in   = k_next;
                  state_in = S_SHIFT_DN;
               end else begin
                  state_in = S_SUB;
               end
            end else if (alu_eq) begin
               status_in   = STAT_LEFT;
               hi_addr_in  = k_ff;
               then_low_in = 1'b0;
               state_in    = S_WR_HIGH;
            end else if (eq_end_ff) begin
               status_in = STAT_RIGHT;
               state_in  = S_WR_LOW;
            end else if (count_ff == CNT_BITS'(MAX_HOLES)) begin
               status_in = STAT_FULL;
               state_in  = S_RESULT;
            end else begin
               status_in   = STAT_SPLIT;
               hi_addr_in  = k_next[IDX_BITS-1:0];
               then_low_in = 1'b1;
               if (k_next < count_ff) begin
                  rd_addr  = count_last[IDX_BITS-1:0];
                  ptr_in   = count_last;
                  state_in = S_SHIFT_UP;
               end else begin
                  state_in = S_WR_HIGH;
               end
            end
         end
         S_SHIFT_DN: begin
            // Move each later entry down by one
            wr_en   = 1'b1;
            wr_addr = ptr_dec[IDX_BITS-1:0];
            wr_data = entry;
            if (ptr_inc < count_ff) begin
               ptr_in  = ptr_inc;
               rd_addr = ptr_inc[IDX_BITS-1:0];
            end else begin
               state_in = S_SUB;
            end
         end
         S_SHIFT_UP: begin
            // Move each later entry up by one, last entry first
            wr_en   = 1'b1;
            wr_addr = ptr_wr_up[IDX_BITS-1:0];
            wr_data = entry;
            if (ptr_ff > k_next) begin
               ptr_in  = ptr_dec;
               rd_addr = ptr_dec[IDX_BITS-1:0];
            end else begin
               state_in = S_WR_HIGH;
            end
         end
         S_WR_HIGH: begin
            // Write the part of the hole above the range
            wr_en             = 1'b1;
            wr_addr           = hi_addr_ff;
            wr_data.start_ofs = hi_ff;
            wr_data.end_ofs   = fend_ff;
            state_in          = then_low_ff ? S_WR_LOW : S_SUB;
         end
         S_WR_LOW: begin
            // Write the part of the hole below the range
            wr_en             = 1'b1;
            wr_addr           = k_ff;
            wr_data.start_ofs = fstart_ff;
            wr_data.end_ofs   = lo_ff;
            state_in          = S_SUB;
         end
         S_SUB: begin
            alu_a    = hi_ff;
            alu_b    = lo_ff;
            diff_in  = alu_sum;
            state_in = S_ADD;
         end
         S_ADD: begin
            // Update the byte total and the hole count
            alu_op      = ALU_ADD;
            alu_a       = received_ff;
            alu_b       = diff_ff;
            received_in = alu_sum;
            if (status_ff == STAT_REMOVED) begin
               count_in = count_last;
            end else if (status_ff == STAT_SPLIT) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Reload the table with one hole over the whole file
      if (csr_write_enable) begin
         wr_en             = 1'b1;
         wr_addr           = '0;
         wr_data.start_ofs = '0;
         wr_data.end_ofs   = csr_write_data;
         received_in       = '0;
         count_in          = (csr_write_data != '0) ? CNT_BITS'(1) : '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         received_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         received_ff <= received_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      fstart_ff   <= fstart_in;
      fend_ff     <= fend_in;
      diff_ff     <= diff_in;
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      k_ff        <= k_in;
      hi_addr_ff  <= hi_addr_in;
      found_ff    <= found_in;
      eq_end_ff   <= eq_end_in;
      then_low_ff <= then_low_in;
      status_ff   <= status_in;
   end

endmodule

`default_nettype wire

// ===== hdl/missing_range_tracker.sv =====
// Top level of the missing range tracker: sequencer, output register, checks.
`default_nettype none

// Tracks the byte ranges still missing from a file as a sorted table of up to
// 64 holes held in a RAM. A write of the size register loads one hole over the
// whole file (none for size zero) and clears the byte count. Each request
// transaction names a received range [range_start, range_end) and returns one
// response transaction with a status, the bytes received so far, the holes
// left and a completion flag. A request scans the table entries up to the
// last hole at or before range_start, plus one, moves the later entries when
// a hole is removed or split, and makes 0 to 2 entry writes: every step goes
// through one shared add/compare unit and the single RAM port pair. Requests
// that end early (empty range, no hole, overrun, full table) stop before the
// moves and writes. The next request is taken while a response still waits
// in the output register.

module missing_range_tracker (
   input  logic                            clock,
   input  logic                            reset,
   mrt_req_if.sink                         req_bus,
   mrt_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [mrt_pkg::OFFSET_BITS-1:0] csr_write_data
);
   import mrt_pkg::*;

   logic       res_valid;
   logic       res_ready;
   result_type res;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;

   mrt_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .range_start      (req_bus.range_start),
      .range_end        (req_bus.range_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res)
   );

   // Load the output register when it is empty or being drained
   assign res_ready    = !out_valid_ff || rsp_bus.ready;
   assign out_valid_in = (res_valid && res_ready) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   // Drive the response channel
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_ff.status;
   assign rsp_bus.received_bytes = out_ff.received;
   assign rsp_bus.holes_left     = out_ff.holes;
   assign rsp_bus.complete       = out_ff.complete;

   // A request transaction closes the request side for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a transaction was in progress");

   // No result is offered right after a request is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !res_valid)
      else $error("result offered in the cycle after a request");

   // A handed-over result shows up on the response channel
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> rsp_bus.valid)
      else $error("handed-over result missing from the response channel");

endmodule

`default_nettype wire

// ===== verif/mrt_hole_checker.sv =====
// Checker for the missing range tracker: tracks the hole table and scores every response.
`timescale 1ns / 1ps

module mrt_hole_checker
   import mrt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   mrt_req_if                     req_bus,
   mrt_rsp_if                     rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [OFFSET_BITS-1:0] csr_write_data,
   output int                     fail_count,
   output int                     reports_owed
);

   // Shadow of the hole table and the running byte count
   logic [OFFSET_BITS-1:0] gap_lo [MAX_HOLES];
   logic [OFFSET_BITS-1:0] gap_hi [MAX_HOLES];
   int                     gap_count;
   logic [RECV_BITS-1:0]   bytes_in;

   // Responses owed by the block, oldest first
   result_type             pending_reports [$];

   // Reload the table with one hole over the whole file
   function automatic void reload_table(input logic [OFFSET_BITS-1:0] size);
      bytes_in = '0;
      if (size == '0) begin
         gap_count = 0;
      end else begin
         gap_lo[0] = '0;
         gap_hi[0] = size;
         gap_count = 1;
      end
   endfunction

   // Mark [lo, hi) as received and return the outcome
   function automatic status_type apply_range(input logic [OFFSET_BITS-1:0] lo,
                                              input logic [OFFSET_BITS-1:0] hi);
      int k;
      int i;
      if (lo >= hi) return STAT_EMPTY;
      // Hole starts are strictly ascending, so keep the last one at or below lo
      k = -1;
      for (i = 0; i < gap_count; i++) begin
         if (gap_lo[i] <= lo) k = i;
      end
      if (k < 0) return STAT_NO_HOLE;
      if (gap_hi[k] < hi) return STAT_OVERRUN;
      if (gap_lo[k] == lo && gap_hi[k] == hi) begin
         // Drop the hole and close up the table
         for (i = k; i + 1 < gap_count; i++) begin
            gap_lo[i] = gap_lo[i + 1];
            gap_hi[i] = gap_hi[i + 1];
         end
         gap_count--;
         bytes_in += hi - lo;
         return STAT_REMOVED;
      end
      if (gap_lo[k] == lo) begin
         gap_lo[k] = hi;
         bytes_in += hi - lo;
         return STAT_LEFT;
      end
      if (gap_hi[k] == hi) begin
         gap_hi[k] = lo;
         bytes_in += hi - lo;
         return STAT_RIGHT;
      end
      if (gap_count >= MAX_HOLES) return STAT_FULL;
      // Open a slot after the hole and split it around the range
      for (i = gap_count; i > k + 1; i--) begin
         gap_lo[i] = gap_lo[i - 1];
         gap_hi[i] = gap_hi[i - 1];
      end
      gap_lo[k + 1] = hi;
      gap_hi[k + 1] = gap_hi[k];
      gap_hi[k]     = lo;
      gap_count++;
      bytes_in += hi - lo;
      return STAT_SPLIT;
   endfunction

   function automatic result_type predict_report(input logic [OFFSET_BITS-1:0] lo,
                                                 input logic [OFFSET_BITS-1:0] hi);
      result_type r;
      r.status   = apply_range(lo, hi);
      r.received = bytes_in;
      r.holes    = gap_count[HOLES_BITS-1:0];
      r.complete = (gap_count == 0);
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
      end
   endtask

   // Score responses, follow register writes, and predict each request
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         gap_count = 0;
         bytes_in  = '0;
         pending_reports.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request outstanding", $realtime);
            end else begin
               want = pending_reports.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_bus.status));
               compare_field("received_bytes", 64'(want.received),
                             64'(rsp_bus.received_bytes));
               compare_field("holes_left", 64'(want.holes), 64'(rsp_bus.holes_left));
               compare_field("complete", 64'(want.complete), 64'(rsp_bus.complete));
            end
         end
         if (csr_write_enable) reload_table(csr_write_data);
         if (req_bus.valid && req_bus.ready) begin
            want = predict_report(req_bus.range_start, req_bus.range_end);
            pending_reports = {pending_reports, want};
         end
      end
      reports_owed = pending_reports.size();
   end

endmodule

// ===== verif/missing_range_tracker_tb.sv =====
// Testbench top for the missing range tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module missing_range_tracker_tb;
   import mrt_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1300;
   localparam int MAX_CHUNKS   = 160;
   localparam logic [OFFSET_BITS-1:0] TOP_OFS = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable;
   logic [OFFSET_BITS-1:0] csr_write_data;
   int                     fail_count;
   int                     reports_owed;
   int                     gap_pct;
   int                     stall_pct;
   int                     stall_left;
   int                     items_sent;
   int                     cycle_count;

   mrt_req_if req_bus ();
   mrt_rsp_if rsp_bus ();

   missing_range_tracker dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   mrt_hole_checker hole_check (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .reports_owed     (reports_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one
   function automatic int pause_len();
      if ($urandom_range(9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] rand_offset();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[OFFSET_BITS-1:0];
   endfunction

   // Stall the response channel at random
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left = pause_len() - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Drive one request transaction; returns at the falling edge after acceptance
   task automatic deliver_range(input logic [OFFSET_BITS-1:0] lo,
                                input logic [OFFSET_BITS-1:0] hi);
      int gap;
      gap = ($urandom_range(99) < gap_pct) ? pause_len() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.range_start <= lo;
      req_bus.range_end   <= hi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Drain all responses, then write the size register
   task automatic set_file_size(input logic [OFFSET_BITS-1:0] size);
      req_bus.valid <= 1'b0;
      while (reports_owed != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Malformed or stale ranges around the file
   task automatic send_noise(input logic [OFFSET_BITS-1:0] lo,
                             input logic [OFFSET_BITS-1:0] hi);
      logic [OFFSET_BITS-1:0] x;
      case ($urandom_range(3))
         0: begin
            x = rand_offset();
            deliver_range(x, x - OFFSET_BITS'($urandom_range(0, 3)));
         end
         1: deliver_range(rand_offset(), rand_offset());
         2: deliver_range(lo, hi + 1);
         default: deliver_range(lo, hi);
      endcase
   endtask

   // Cut a file into chunks and deliver them out of order; a comb file first
   // delivers every other chunk so the table fills up
   task automatic deliver_file(input int n, input bit wide, input bit comb);
      logic [OFFSET_BITS-1:0] sz     [MAX_CHUNKS];
      logic [OFFSET_BITS-1:0] lo_of  [MAX_CHUNKS];
      logic [OFFSET_BITS-1:0] hi_of  [MAX_CHUNKS];
      bit                     got    [MAX_CHUNKS];
      logic [OFFSET_BITS-1:0] total;
      int                     i;
      int                     pick;
      int                     last;
      int                     left;
      total = '0;
      for (i = 0; i < n; i++) begin
         if (comb)                        sz[i] = OFFSET_BITS'($urandom_range(1, 3));
         else if ($urandom_range(3) == 0) sz[i] = (rand_offset() >> 7) + 1;
         else                             sz[i] = OFFSET_BITS'($urandom_range(1, 1000));
         if (i > 0) total += sz[i];
      end
      // A wide file ends at the top offset so the high bits get exercised
      if (wide) sz[0] = TOP_OFS - total;
      total = '0;
      for (i = 0; i < n; i++) begin
         lo_of[i] = total;
         total   += sz[i];
         hi_of[i] = total;
         got[i]   = 1'b0;
      end
      set_file_size(total);
      left = n;
      if (comb) begin
         for (i = 1; i < n; i += 2) begin
            deliver_range(lo_of[i], hi_of[i]);
            got[i] = 1'b1;
            left--;
         end
      end
      while (left > 0) begin
         pick = $urandom_range(n - 1);
         if ($urandom_range(99) < 12) begin
            send_noise(lo_of[pick], hi_of[pick]);
         end else begin
            while (got[pick]) pick = (pick + 1) % n;
            last = pick;
            // Now and then merge with the next chunk if it is still missing
            if ($urandom_range(4) == 0 && pick + 1 < n && !got[pick + 1]) last = pick + 1;
            deliver_range(lo_of[pick], hi_of[last]);
            for (i = pick; i <= last; i++) got[i] = 1'b1;
            left -= last - pick + 1;
         end
      end
      // Resend a chunk once the file is done
      deliver_range(lo_of[0], hi_of[0]);
   endtask

   // Give up at the cycle limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("missing_range_tracker_tb NOT OK");
      $finish;
   end

   initial begin
      int round;
      req_bus.valid       = 1'b0;
      req_bus.range_start = '0;
      req_bus.range_end   = '0;
      rsp_bus.ready       = 1'b0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      gap_pct             = 20;
      stall_pct           = 20;
      stall_left          = 0;
      items_sent          = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Largest file: whole file at once, then trims down to completion
      set_file_size(TOP_OFS);
      deliver_range('0, TOP_OFS);
      deliver_range('0, 1);
      set_file_size(TOP_OFS);
      deliver_range(TOP_OFS - 1, TOP_OFS);
      deliver_range(1, TOP_OFS - 1);
      deliver_range(TOP_OFS, TOP_OFS);
      deliver_range('0, 1);

      // Small file: empty ranges, every trim, splits, no hole, overruns, removals
      set_file_size(100);
      deliver_range(50, 50);
      deliver_range(60, 10);
      deliver_range(0, 10);
      deliver_range(90, 100);
      deliver_range(40, 50);
      deliver_range(20, 30);
      deliver_range(5, 15);
      deliver_range(15, 35);
      deliver_range(25, 27);
      deliver_range(95, 100);
      deliver_range(10, 20);
      deliver_range(30, 40);
      deliver_range(50, 90);

      // Zero size: complete at once
      set_file_size('0);
      deliver_range('0, 5);
      deliver_range('0, '0);

      // Random files under changing idle patterns
      round = 0;
      while (items_sent < RANDOM_ITEMS) begin
         round++;
         case ($urandom_range(3))
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 15; stall_pct = 15; end
            2: begin gap_pct = 50; stall_pct = 30; end
            default: begin gap_pct = 10; stall_pct = 60; end
         endcase
         if (round % 12 == 1) begin
            deliver_file($urandom_range(129, 141), 1'b0, 1'b1);
         end else if ($urandom_range(9) == 0) begin
            set_file_size('0);
            repeat (3) send_noise(rand_offset(), rand_offset());
         end else begin
            deliver_file($urandom_range(1, 40), $urandom_range(5) == 0, 1'b0);
         end
      end

      // Drain, then let the block settle
      req_bus.valid <= 1'b0;
      while (reports_owed != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("missing_range_tracker_tb OK");
      end else begin
         $display("missing_range_tracker_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mrt_pkg.sv
hdl/mrt_ifs.sv
hdl/mrt_alu.sv
hdl/mrt_ram.sv
hdl/mrt_seq.sv
hdl/missing_range_tracker.sv
verif/mrt_hole_checker.sv
verif/missing_range_tracker_tb.sv
